### rtl/rict_pkg.sv
// Shared types, codes and constants for the refcounted inode cache table.
package rict_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned NO_W      = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned REF_W     = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ST_W      = 4;

  localparam logic [NO_W-1:0]  INVALID_NO = NO_W'(1);
  localparam logic [REF_W-1:0] REF_MAX    = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_DIRTY   = 2'd2,
    ACT_FLUSH   = 2'd3
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_HIT        = 4'd0,
    ST_MISS       = 4'd1,
    ST_BAD_NO     = 4'd2,
    ST_FULL       = 4'd3,
    ST_RELEASED   = 4'd4,
    ST_DELETED    = 4'd5,
    ST_UNDERFLOW  = 4'd6,
    ST_DIRTIED    = 4'd7,
    ST_FLUSH_ENT  = 4'd8,
    ST_FLUSH_NONE = 4'd9
  } stat_t;

  // what an emitted item is built from
  typedef enum logic [2:0] {
    RK_REQ,
    RK_SLOT,
    RK_BAD,
    RK_FMID,
    RK_FLAST,
    RK_FNONE
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_DIV,
    S_SRD,
    S_SEV,
    S_REQ_DONE,
    S_ORD,
    S_OEV,
    S_BAD,
    S_FRD,
    S_FEV,
    S_FEND
  } state_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      rd;
    logic      probe;
    logic      advance;
    logic      emit;
    res_kind_t kind;
  } rict_cmd_t;

  typedef struct packed {
    act_t act;
    logic bad_no;
    logic slot_oor;
    logic div_last;
    logic hit_now;
    logic cnt_end;
    logic ptr_end;
    logic rd_dirty;
    logic pend_valid;
    logic out_free;
  } rict_sts_t;

endpackage

### rtl/rict_in_if.sv
// Input channel: one cache operation per item.
interface rict_in_if;
  import rict_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [NO_W-1:0]   inode_number;
  logic [SLOT_W-1:0] slot;
  logic              links_gone;

  modport source(output valid, action, inode_number, slot, links_gone, input ready);
  modport sink(input valid, action, inode_number, slot, links_gone, output ready);
endinterface

### rtl/rict_out_if.sv
// Result channel: one cache result per item.
interface rict_out_if;
  import rict_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot_index;
  logic [NO_W-1:0]   tag_number;
  logic              load_needed;
  logic              writeback_needed;
  logic [NO_W-1:0]   writeback_number;
  logic [REF_W-1:0]  ref_count;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  miss_total;
  logic              last;

  modport source(output valid, status, slot_index, tag_number, load_needed,
                 writeback_needed, writeback_number, ref_count, hit_total,
                 miss_total, last, input ready);
  modport sink(input valid, status, slot_index, tag_number, load_needed,
               writeback_needed, writeback_number, ref_count, hit_total,
               miss_total, last, output ready);
endinterface

### rtl/rict_ram.sv
// Generic single write port, single read port RAM with registered read.
module rict_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

### rtl/rict_dp.sv
// Datapath: slot store, hash remainder, ring probe, counters and result register.
module rict_dp #(
  parameter int unsigned SLOTS = rict_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rict_pkg::rict_cmd_t         cmd,
  output rict_pkg::rict_sts_t         sts,
  input  logic [rict_pkg::ACT_W-1:0]  in_action,
  input  logic [rict_pkg::NO_W-1:0]   in_inode_number,
  input  logic [rict_pkg::SLOT_W-1:0] in_slot,
  input  logic                        in_links_gone,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [rict_pkg::ST_W-1:0]   out_status,
  output logic [rict_pkg::SLOT_W-1:0] out_slot_index,
  output logic [rict_pkg::NO_W-1:0]   out_tag_number,
  output logic                        out_load_needed,
  output logic                        out_writeback_needed,
  output logic [rict_pkg::NO_W-1:0]   out_writeback_number,
  output logic [rict_pkg::REF_W-1:0]  out_ref_count,
  output logic [rict_pkg::CNT_W-1:0]  out_hit_total,
  output logic [rict_pkg::CNT_W-1:0]  out_miss_total,
  output logic                        out_last
);
  import rict_pkg::*;

  localparam int unsigned PW   = $clog2(SLOTS);
  localparam int unsigned FW   = 16;
  localparam int unsigned RCW  = FW + 2;
  localparam int unsigned PRW  = FW + RCW;
  localparam int unsigned DSH  = FW + PW;
  localparam int unsigned EW   = NO_W + REF_W + 1;
  localparam int unsigned SLW1 = SLOT_W + 1;
  localparam logic [PW-1:0]   LAST_SLOT = PW'(SLOTS - 1);
  localparam logic [SLW1-1:0] SLOT_LIM  = SLW1'(SLOTS);
  // byte weights 256^k mod SLOTS and the reciprocal for a 16-bit dividend
  localparam logic [FW-1:0]   FC1       = FW'((64'd1 << 8) % SLOTS);
  localparam logic [FW-1:0]   FC2       = FW'((64'd1 << 16) % SLOTS);
  localparam logic [FW-1:0]   FC3       = FW'((64'd1 << 24) % SLOTS);
  localparam logic [FW-1:0]   MODF      = FW'(SLOTS);
  localparam logic [RCW-1:0]  RECIP     = RCW'(((64'd1 << DSH) + SLOTS - 1) / SLOTS);

  act_t              act_r;
  logic [NO_W-1:0]   no_r;
  logic [SLOT_W-1:0] slot_in_r;
  logic              gone_r;
  logic [FW-1:0]     fold_r;
  logic [FW-1:0]     quo_r;
  logic [1:0]        div_cnt_r;
  logic [PW-1:0]     ptr_r;
  logic [PW-1:0]     cnt_r;
  logic              hit_r;
  logic              free_r;
  logic [PW-1:0]     sel_slot_r;
  logic [NO_W-1:0]   sel_tag_r;
  logic [REF_W-1:0]  sel_ref_r;
  logic              sel_dirty_r;
  logic              pend_r;
  logic [PW-1:0]     pend_slot_r;
  logic [NO_W-1:0]   pend_tag_r;
  logic [REF_W-1:0]  pend_ref_r;
  logic [CNT_W-1:0]  hits_r;
  logic [CNT_W-1:0]  misses_r;
  logic [SLOTS-1:0]  vld_r;
  logic              rd_vld_r;

  logic [FW-1:0]     fold_nxt;
  logic [PRW-1:0]    prod;
  logic [FW-1:0]     quo_nxt;
  logic [FW-1:0]     rem_full;
  logic [PW-1:0]     ptr_nxt;
  logic [PW-1:0]     rd_addr;
  logic [EW-1:0]     ram_rdata;
  logic [NO_W-1:0]   rd_tag;
  logic [REF_W-1:0]  rd_ref;
  logic              rd_dirty;
  logic              free_cond;
  logic [REF_W-1:0]  sel_inc;
  logic [REF_W-1:0]  rel_nr;
  logic              out_free;

  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic              vld_clr;
  logic              hit_inc;
  logic              miss_inc;
  stat_t             res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [NO_W-1:0]   res_tag;
  logic              res_load;
  logic              res_wb;
  logic [NO_W-1:0]   res_wbno;
  logic [REF_W-1:0]  res_ref;
  logic              res_last;
  logic [CNT_W-1:0]  hits_nxt;
  logic [CNT_W-1:0]  misses_nxt;

  // remainder by the slot count in steps: fold the bytes with their
  // weights, take the quotient by reciprocal multiply, then subtract
  assign fold_nxt = FW'(no_r[7:0]) + FW'(no_r[15:8]) * FC1 +
                    FW'(no_r[23:16]) * FC2 + FW'(no_r[31:24]) * FC3;
  assign prod     = PRW'(fold_r) * PRW'(RECIP);
  assign quo_nxt  = FW'(prod >> DSH);
  assign rem_full = fold_r - quo_r * MODF;
  assign ptr_nxt = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
  assign rd_addr = (act_r == ACT_RELEASE || act_r == ACT_DIRTY) ? slot_in_r[PW-1:0] : ptr_r;

  rict_ram #(.W(EW), .D(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // an entry never written, or deleted, reads as an invalid, unreferenced, clean entry
  assign rd_tag    = rd_vld_r ? ram_rdata[EW-1 -: NO_W] : INVALID_NO;
  assign rd_ref    = rd_vld_r ? ram_rdata[REF_W:1] : '0;
  assign rd_dirty  = rd_vld_r & ram_rdata[0];
  assign free_cond = (rd_tag == INVALID_NO) || (rd_ref == '0);
  assign sel_inc   = (sel_ref_r == REF_MAX) ? sel_ref_r : sel_ref_r + 1'b1;
  assign rel_nr    = rd_ref - 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign sts.act        = act_r;
  assign sts.bad_no     = (no_r <= INVALID_NO);
  assign sts.slot_oor   = ({1'b0, slot_in_r} >= SLOT_LIM);
  assign sts.div_last   = (div_cnt_r == '0);
  assign sts.hit_now    = (rd_tag == no_r);
  assign sts.cnt_end    = (cnt_r == LAST_SLOT);
  assign sts.ptr_end    = (ptr_r == LAST_SLOT);
  assign sts.rd_dirty   = rd_dirty;
  assign sts.pend_valid = pend_r;
  assign sts.out_free   = out_free;

  always_comb begin
    res_status = ST_HIT;
    res_slot   = '0;
    res_tag    = '0;
    res_load   = 1'b0;
    res_wb     = 1'b0;
    res_wbno   = '0;
    res_ref    = '0;
    res_last   = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = sel_slot_r;
    wr_data    = '0;
    vld_clr    = 1'b0;
    hit_inc    = 1'b0;
    miss_inc   = 1'b0;
    case (cmd.kind) inside
      RK_REQ: begin
        if (hit_r) begin
          res_status = ST_HIT;
          res_slot   = SLOT_W'(sel_slot_r);
          res_tag    = no_r;
          res_ref    = sel_inc;
          wr_en      = 1'b1;
          wr_data    = {no_r, sel_inc, sel_dirty_r};
          hit_inc    = 1'b1;
        end else if (free_r) begin
          res_status = ST_MISS;
          res_slot   = SLOT_W'(sel_slot_r);
          res_tag    = no_r;
          res_load   = 1'b1;
          res_wb     = sel_dirty_r && (sel_tag_r != INVALID_NO);
          res_wbno   = res_wb ? sel_tag_r : '0;
          res_ref    = sel_inc;
          wr_en      = 1'b1;
          wr_data    = {no_r, sel_inc, 1'b0};
          miss_inc   = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      RK_SLOT: begin
        res_slot = slot_in_r;
        res_tag  = rd_tag;
        wr_addr  = slot_in_r[PW-1:0];
        if (act_r == ACT_RELEASE) begin
          if (rd_ref == '0) begin
            res_status = ST_UNDERFLOW;
          end else if (rel_nr == '0 && gone_r) begin
            res_status = ST_DELETED;
            vld_clr    = 1'b1;
          end else begin
            res_status = ST_RELEASED;
            res_ref    = rel_nr;
            wr_en      = 1'b1;
            wr_data    = {rd_tag, rel_nr, rd_dirty};
          end
        end else begin
          res_status = ST_DIRTIED;
          res_ref    = rd_ref;
          wr_en      = (rd_tag != INVALID_NO);
          wr_data    = {rd_tag, rd_ref, 1'b1};
        end
      end
      RK_BAD: begin
        case (act_r)
          ACT_RELEASE: begin
            res_status = ST_UNDERFLOW;
            res_slot   = slot_in_r;
          end
          ACT_DIRTY: begin
            res_status = ST_DIRTIED;
            res_slot   = slot_in_r;
          end
          default: res_status = ST_BAD_NO;
        endcase
      end
      RK_FMID, RK_FLAST: begin
        res_status = ST_FLUSH_ENT;
        res_slot   = SLOT_W'(pend_slot_r);
        res_tag    = pend_tag_r;
        res_wb     = 1'b1;
        res_wbno   = pend_tag_r;
        res_ref    = pend_ref_r;
        res_last   = (cmd.kind == RK_FLAST);
      end
      RK_FNONE: res_status = ST_FLUSH_NONE;
      default: ;
    endcase
    if (!cmd.emit) begin
      wr_en    = 1'b0;
      vld_clr  = 1'b0;
      hit_inc  = 1'b0;
      miss_inc = 1'b0;
    end
    // flush cleans each dirty entry as it passes
    if (cmd.advance && rd_dirty) begin
      wr_en   = 1'b1;
      wr_addr = ptr_r;
      wr_data = {rd_tag, rd_ref, 1'b0};
    end
  end

  assign hits_nxt   = hits_r + CNT_W'(hit_inc);
  assign misses_nxt = misses_r + CNT_W'(miss_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      out_valid <= 1'b0;
      pend_r    <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (vld_clr) begin
        vld_r[wr_addr] <= 1'b0;
      end
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        pend_r <= 1'b0;
      end
      if (cmd.probe) begin
        if (sts.hit_now) begin
          hit_r <= 1'b1;
        end else if (!free_r && free_cond) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.advance && rd_dirty) begin
        pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= act_t'(in_action);
      no_r      <= in_inode_number;
      slot_in_r <= in_slot;
      gone_r    <= in_links_gone;
      div_cnt_r <= 2'd2;
      ptr_r     <= '0;
    end
    if (cmd.div_step) begin
      fold_r    <= fold_nxt;
      quo_r     <= quo_nxt;
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == '0) begin
        ptr_r <= rem_full[PW-1:0];
        cnt_r <= '0;
      end
    end
    if (cmd.rd) begin
      rd_vld_r <= vld_r[rd_addr];
    end
    if (cmd.probe) begin
      if (sts.hit_now || (!free_r && free_cond)) begin
        sel_slot_r  <= ptr_r;
        sel_tag_r   <= rd_tag;
        sel_ref_r   <= rd_ref;
        sel_dirty_r <= rd_dirty;
      end
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.advance) begin
      ptr_r <= ptr_nxt;
      if (rd_dirty) begin
        pend_slot_r <= ptr_r;
        pend_tag_r  <= rd_tag;
        pend_ref_r  <= rd_ref;
      end
    end
    if (cmd.emit) begin
      out_status           <= res_status;
      out_slot_index       <= res_slot;
      out_tag_number       <= res_tag;
      out_load_needed      <= res_load;
      out_writeback_needed <= res_wb;
      out_writeback_number <= res_wbno;
      out_ref_count        <= res_ref;
      out_hit_total        <= hits_nxt;
      out_miss_total       <= misses_nxt;
      out_last             <= res_last;
    end
  end
endmodule

### rtl/rict_ctrl.sv
// Controller: sequences remainder, ring probe, slot update and flush walk.
module rict_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rict_pkg::rict_sts_t sts,
  output rict_pkg::rict_cmd_t cmd
);
  import rict_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.kind  = RK_REQ;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.act) inside
          ACT_REQUEST: state_nxt = sts.bad_no ? S_BAD : S_DIV;
          ACT_RELEASE, ACT_DIRTY: state_nxt = sts.slot_oor ? S_BAD : S_ORD;
          default: state_nxt = S_FRD;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SEV;
      end
      S_SEV: begin
        cmd.probe = 1'b1;
        state_nxt = (sts.hit_now || sts.cnt_end) ? S_REQ_DONE : S_SRD;
      end
      S_REQ_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = RK_REQ;
          state_nxt = S_IDLE;
        end
      end
      S_ORD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_OEV;
      end
      S_OEV: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = RK_SLOT;
          state_nxt = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = RK_BAD;
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FEV;
      end
      S_FEV: begin
        // a held entry goes out only once the next dirty one shows it is not last
        if (!(sts.rd_dirty && sts.pend_valid) || sts.out_free) begin
          cmd.advance = 1'b1;
          if (sts.rd_dirty && sts.pend_valid) begin
            cmd.emit = 1'b1;
            cmd.kind = RK_FMID;
          end
          state_nxt = sts.ptr_end ? S_FEND : S_FRD;
        end
      end
      S_FEND: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = sts.pend_valid ? RK_FLAST : RK_FNONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### rtl/refcounted_inode_cache_table_core.sv
// Top level of the refcounted inode cache table.
//
//   channel   direction  carries
//   in_chan   sink       action, inode_number, slot, links_gone
//   out_chan  source     status, slot, tags, writeback, counts, last
//
// One item at a time. A request: accept, dispatch, hash remainder, then a read and an
// evaluate per slot on the single RAM read port until a hit or all SLOTS are probed,
// then emit. A bad number or slot: accept, dispatch, emit; release and mark dirty read
// their slot before the emit. A flush walks all SLOTS entries, a read and evaluate each.
// Reset clears the valid bits at once; no clearing pass. A full output register
// holds the controller in its emit state until the item is taken.
module refcounted_inode_cache_table_core #(
  parameter int unsigned SLOTS = rict_pkg::SLOTS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  rict_in_if.sink   in_chan,
  rict_out_if.source out_chan
);
  import rict_pkg::*;

  rict_cmd_t cmd;
  rict_sts_t sts;

  rict_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rict_dp #(.SLOTS(SLOTS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_chan.action),
    .in_inode_number      (in_chan.inode_number),
    .in_slot              (in_chan.slot),
    .in_links_gone        (in_chan.links_gone),
    .out_ready            (out_chan.ready),
    .out_valid            (out_chan.valid),
    .out_status           (out_chan.status),
    .out_slot_index       (out_chan.slot_index),
    .out_tag_number       (out_chan.tag_number),
    .out_load_needed      (out_chan.load_needed),
    .out_writeback_needed (out_chan.writeback_needed),
    .out_writeback_number (out_chan.writeback_number),
    .out_ref_count        (out_chan.ref_count),
    .out_hit_total        (out_chan.hit_total),
    .out_miss_total       (out_chan.miss_total),
    .out_last             (out_chan.last)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while an item is in progress");

  a_load_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.load_needed) |-> (out_chan.status == ST_MISS))
    else $error("load reported on a result that is not a miss");

  a_wb_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.writeback_needed) |-> (out_chan.writeback_number == '0))
    else $error("writeback number without a writeback");
`endif
endmodule

### dv/rict_tb_ifs.sv
`timescale 1ns / 100ps
// Interface instances are taken from the RTL; this file holds the tb-side clock-free helpers.
package rict_tb_pkg;
  import rict_pkg::*;

  typedef struct {
    stat_t             status;
    logic [SLOT_W-1:0] slot_index;
    logic [NO_W-1:0]   tag_number;
    logic              load_needed;
    logic              writeback_needed;
    logic [NO_W-1:0]   writeback_number;
    logic [REF_W-1:0]  ref_count;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic              last;
  } cache_res_t;
endpackage

### dv/refcounted_inode_cache_table_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the refcounted inode cache table core: random and directed cache traffic.
module refcounted_inode_cache_table_core_tb;
  import rict_pkg::*;
  import rict_tb_pkg::*;

  localparam int unsigned NSLOT = SLOTS_DEF;

  logic clk;
  logic rst_n;
  bit   failed;
  bit   hold_off;

  rict_in_if  in_chan();
  rict_out_if out_chan();

  refcounted_inode_cache_table_core #(.SLOTS(NSLOT)) DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // predicted cache state
  logic [NO_W-1:0]  tags[NSLOT];
  logic [REF_W-1:0] refs[NSLOT];
  bit               dirty[NSLOT];
  logic [CNT_W-1:0] hit_cnt, miss_cnt;
  cache_res_t       pending_results[$];

  function automatic cache_res_t mk(stat_t st, int unsigned idx, logic [NO_W-1:0] tag,
                                    bit ld, bit wb, logic [NO_W-1:0] wbno,
                                    logic [REF_W-1:0] rc);
    cache_res_t r;
    r.status = st; r.slot_index = idx[SLOT_W-1:0]; r.tag_number = tag;
    r.load_needed = ld; r.writeback_needed = wb; r.writeback_number = wbno;
    r.ref_count = rc; r.hit_total = hit_cnt; r.miss_total = miss_cnt; r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_cache(act_t act, logic [NO_W-1:0] no,
                                        logic [SLOT_W-1:0] s, bit gone);
    cache_res_t res[$];
    int unsigned start, k, idx;
    bit found;
    logic [NO_W-1:0] old;
    found = 0;
    case (act)
      ACT_REQUEST: begin
        if (no <= INVALID_NO) begin
          res.push_back(mk(ST_BAD_NO, 0, 0, 0, 0, 0, 0));
        end else begin
          start = no % NSLOT;
          for (k = 0; k < NSLOT && !found; k++) begin
            idx = (start + k) % NSLOT;
            if (tags[idx] == no) begin
              found = 1;
              if (refs[idx] != REF_MAX) refs[idx]++;
              hit_cnt++;
              res.push_back(mk(ST_HIT, idx, no, 0, 0, 0, refs[idx]));
            end
          end
          for (k = 0; k < NSLOT && !found; k++) begin
            idx = (start + k) % NSLOT;
            if (tags[idx] == INVALID_NO || refs[idx] == 0) begin
              found = 1;
              old = (dirty[idx] && tags[idx] != INVALID_NO) ? tags[idx] : '0;
              tags[idx] = no; dirty[idx] = 0;
              if (refs[idx] != REF_MAX) refs[idx]++;
              miss_cnt++;
              res.push_back(mk(ST_MISS, idx, no, 1, old != 0, old, refs[idx]));
            end
          end
          if (!found) res.push_back(mk(ST_FULL, 0, 0, 0, 0, 0, 0));
        end
      end
      ACT_RELEASE: begin
        if (s >= NSLOT) res.push_back(mk(ST_UNDERFLOW, s, 0, 0, 0, 0, 0));
        else if (refs[s] == 0) res.push_back(mk(ST_UNDERFLOW, s, tags[s], 0, 0, 0, 0));
        else begin
          refs[s]--;
          if (refs[s] == 0 && gone) begin
            old = tags[s]; tags[s] = INVALID_NO; dirty[s] = 0;
            res.push_back(mk(ST_DELETED, s, old, 0, 0, 0, 0));
          end else res.push_back(mk(ST_RELEASED, s, tags[s], 0, 0, 0, refs[s]));
        end
      end
      ACT_DIRTY: begin
        if (s >= NSLOT) res.push_back(mk(ST_DIRTIED, s, 0, 0, 0, 0, 0));
        else begin
          if (tags[s] != INVALID_NO) dirty[s] = 1;
          res.push_back(mk(ST_DIRTIED, s, tags[s], 0, 0, 0, refs[s]));
        end
      end
      default: begin
        for (k = 0; k < NSLOT; k++)
          if (dirty[k]) begin
            dirty[k] = 0;
            res.push_back(mk(ST_FLUSH_ENT, k, tags[k], 0, 1, tags[k], refs[k]));
          end
        if (res.size() == 0) res.push_back(mk(ST_FLUSH_NONE, 0, 0, 0, 0, 0, 0));
      end
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[j]) pending_results.push_back(res[j]);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays up after an accept until the next item or a gap replaces it
  task automatic send_op(act_t act, logic [NO_W-1:0] no, logic [SLOT_W-1:0] s, bit gone,
                         bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.action       <= act;
    in_chan.inode_number <= no;
    in_chan.slot         <= s;
    in_chan.links_gone   <= gone;
    do @(posedge clk); while (!in_chan.ready);
    predict_cache(act, no, s, gone);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_chan.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 20) out_chan.ready <= 1'b0;
      else out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cache_res_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, status %0d", out_chan.status);
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (out_chan.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_chan.status); failed = 1; end
        if (out_chan.slot_index !== e.slot_index) begin
          $error("slot_index exp %0d got %0d", e.slot_index, out_chan.slot_index);
          failed = 1; end
        if (out_chan.tag_number !== e.tag_number) begin
          $error("tag_number exp %0h got %0h", e.tag_number, out_chan.tag_number);
          failed = 1; end
        if (out_chan.load_needed !== e.load_needed) begin
          $error("load_needed exp %0b got %0b", e.load_needed, out_chan.load_needed);
          failed = 1; end
        if (out_chan.writeback_needed !== e.writeback_needed) begin
          $error("writeback_needed exp %0b got %0b", e.writeback_needed,
                 out_chan.writeback_needed); failed = 1; end
        if (out_chan.writeback_number !== e.writeback_number) begin
          $error("writeback_number exp %0h got %0h", e.writeback_number,
                 out_chan.writeback_number); failed = 1; end
        if (out_chan.ref_count !== e.ref_count) begin
          $error("ref_count exp %0d got %0d", e.ref_count, out_chan.ref_count);
          failed = 1; end
        if (out_chan.hit_total !== e.hit_total) begin
          $error("hit_total exp %0d got %0d", e.hit_total, out_chan.hit_total);
          failed = 1; end
        if (out_chan.miss_total !== e.miss_total) begin
          $error("miss_total exp %0d got %0d", e.miss_total, out_chan.miss_total);
          failed = 1; end
        if (out_chan.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_chan.last); failed = 1; end
      end
    end
  end

  // numbers mostly from a small pool so hits, evictions and releases recur
  logic [NO_W-1:0] pool[16];

  function automatic logic [NO_W-1:0] pick_no();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return pool[$urandom_range(0, 15)];
    if (p < 75) return $urandom_range(0, 1);
    return $urandom();
  endfunction

  task automatic test_directed();
    send_op(ACT_FLUSH, 0, 0, 0);                      // nothing dirty
    send_op(ACT_REQUEST, 0, 0, 0);                    // bad numbers
    send_op(ACT_REQUEST, 1, 0, 0);
    send_op(ACT_REQUEST, 32'hFFFF_FFFF, 0, 0);
    send_op(ACT_REQUEST, 32'hFFFF_FFFF, 0, 0);        // hit
    send_op(ACT_REQUEST, 32'h0000_0041, 0, 0);        // same start slot, linear probe
    send_op(ACT_REQUEST, 32'h0000_0081, 0, 0);
    send_op(ACT_DIRTY, 0, 6'd63, 0);
    send_op(ACT_DIRTY, 0, 6'd2, 0);
    send_op(ACT_DIRTY, 0, 6'd10, 0);                  // empty slot stays clean
    send_op(ACT_RELEASE, 0, 6'd10, 1);                // underflow
    send_op(ACT_RELEASE, 0, 6'd1, 1);                 // deleted
    send_op(ACT_RELEASE, 0, 6'd63, 0);
    send_op(ACT_RELEASE, 0, 6'd63, 1);                // deleted: last reference dropped with links gone
    send_op(ACT_REQUEST, 32'h0000_00BF, 0, 0);        // takes the freed slot 63, no writeback
    send_op(ACT_FLUSH, 0, 0, 0);
    send_op(ACT_REQUEST, 32'hAAAA_5555, 0, 0);
    send_op(ACT_REQUEST, 32'h5555_AAAA, 0, 0);
  endtask

  task automatic test_full_table();
    int unsigned k;
    for (k = 0; k < NSLOT + 2; k++) send_op(ACT_REQUEST, 32'h100 + k * 7, 0, 0, k[0]);
    send_op(ACT_DIRTY, 0, 6'd20, 0);
    send_op(ACT_RELEASE, 0, 6'd20, 0);
    send_op(ACT_REQUEST, 32'h7777_0000, 0, 0);        // takes the freed slot
  endtask

  task automatic test_backpressure();
    int unsigned k;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (k = 0; k < 8; k++) send_op(ACT_DIRTY, 0, SLOT_W'(k * 8), 0, 1);
    join
    send_op(ACT_FLUSH, 0, 0, 0);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned k, p;
    logic [SLOT_W-1:0] s;
    for (k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      s = SLOT_W'($urandom_range(0, 63));
      if (p < 45) send_op(ACT_REQUEST, pick_no(), SLOT_W'($urandom()), 1'($urandom()));
      else if (p < 75) send_op(ACT_RELEASE, $urandom(), s, 1'($urandom_range(0, 1)));
      else if (p < 92) send_op(ACT_DIRTY, $urandom(), s, 1'($urandom()));
      else send_op(ACT_FLUSH, $urandom(), s, 1'($urandom()));
    end
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int unsigned k;
    failed = 0; hold_off = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0; in_chan.action = ACT_REQUEST;
    in_chan.inode_number = '0; in_chan.slot = '0; in_chan.links_gone = 1'b0;
    for (k = 0; k < NSLOT; k++) begin
      tags[k] = INVALID_NO; refs[k] = 0; dirty[k] = 0;
    end
    hit_cnt = 0; miss_cnt = 0;
    for (k = 0; k < 16; k++) pool[k] = (k < 8) ? (k * NSLOT + 5 + k[0]) : $urandom() | 2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(84);
    drain();
    if (!failed && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
